// ----- hw/rtl/bps_pkg.sv -----
// shared types, constants and power tables for the blinn-phong shader core
`default_nettype none

package bps_pkg;

	// power table size and index width
	localparam int POW_TABLE_DEPTH = 256;
	localparam int POW_IDX_W       = $clog2(POW_TABLE_DEPTH);

	// datapath widths fixed by the field formats
	localparam int VEC_W     = 16;
	localparam int SUM_W     = 17;
	localparam int PROD_W    = 33;
	localparam int SQR_W     = 34;
	localparam int DOTS_W    = 35;
	localparam int DOT_W     = 34;
	localparam int LEN2_W    = 34;
	localparam int SQ_W      = 25;
	localparam int SQ_X_W    = 2 * SQ_W;
	localparam int CH_W      = 16;
	localparam int RGB_W     = 48;
	localparam int FALL_W    = 33;
	localparam int LG_W      = 22;
	localparam int E_W       = 39;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	localparam logic [FALL_W-1:0] FALLOFF_CAP = 33'h1_0000_0000;
	localparam logic [FALL_W-1:0] FALLOFF_ONE = 33'h0_0001_0000;

	// back-face diffuse override (1,1,0)
	localparam logic [CH_W-1:0] BACK_RED   = 16'd4096;
	localparam logic [CH_W-1:0] BACK_GREEN = 16'd4096;
	localparam logic [CH_W-1:0] BACK_BLUE  = 16'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPEC_RED        = 3'd0,
		CFG_SPEC_GREEN      = 3'd1,
		CFG_SPEC_BLUE       = 3'd2,
		CFG_SHININESS       = 3'd3,
		CFG_DIFFUSE_PRESENT = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [RGB_W-1:0] diffuse_rgb;
		logic             front_face;
	} side_t;

	typedef logic [POW_TABLE_DEPTH-1:0][15:0] log_tab_t;
	typedef logic [POW_TABLE_DEPTH-1:0][16:0] exp_tab_t;

	// truncated q.16 fraction of log2(y), y in q2.30 within [1,2)
	function automatic logic [15:0] frac_log2(input logic [63:0] y_in);
		logic [63:0] y;
		logic [15:0] r;
		y = y_in;
		r = '0;
		for (int b = 0; b < 16; b++) begin
			y = (y * y) >> 30;
			r = {r[14:0], 1'b0};
			if (y >= 64'h8000_0000) begin
				y = y >> 1;
				r[0] = 1'b1;
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_log2_tab();
		log_tab_t    tab;
		logic [63:0] y;
		for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
			y = (64'd1 << 30) + ((64'(i) << 30) / POW_TABLE_DEPTH);
			tab[i] = frac_log2(y);
		end
		return tab;
	endfunction

	// smallest q1.16 value whose truncated log2 reaches each step
	function automatic exp_tab_t build_exp2_tab();
		exp_tab_t    tab;
		logic [63:0] t;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
			t  = (64'(i) << 16) / POW_TABLE_DEPTH;
			lo = 64'd65536;
			hi = 64'd131071;
			for (int it = 0; it < 18; it++) begin
				if (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (64'(frac_log2(mid << 14)) >= t)
						hi = mid;
					else
						lo = mid + 64'd1;
				end
			end
			tab[i] = lo[16:0];
		end
		return tab;
	endfunction

	localparam log_tab_t LOG2_TAB = build_log2_tab();
	localparam exp_tab_t EXP2_TAB = build_exp2_tab();

endpackage

`default_nettype wire

// ----- hw/rtl/blinn_phong_shader_core.sv -----
// top level of the blinn-phong shader core: one shaded color per surface hit
//
// usage
//   input channel: in_valid / in_stall with the normal, light and view vectors,
//   the diffuse sample and the front-face flag; a beat moves when in_valid is
//   high and in_stall is low. output channel: out_valid / out_stall with the
//   three saturated q4.12 color channels, one result beat per input beat, in order.
//   config: cfg_write with cfg_index and cfg_data sets the specular color,
//   shininess and diffuse-present registers; write only while the core is empty.
// pipeline and throughput
//   three front stages for the halfway sum and dot products, 25 one-bit steps
//   of the square root, one quotient bit per stage of the cosine divider, and
//   five stages for log2, multiply, exp2, specular scale and output add.
//   one beat is accepted every cycle while the output is not stalled.
// reset and stall
//   reset clears all valid bits and loads the register reset values; no
//   clearing pass is needed. a stall on the output freezes the whole pipe;
//   in_stall is raised in the same cycle, so nothing is lost or repeated.
`default_nettype none

module blinn_phong_shader_core
	import bps_pkg::*;
#(
	parameter int VEC_FRAC_BITS = 14
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,

	input  wire logic                     cfg_write,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,

	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [VEC_W-1:0]  normal_x,
	input  wire logic signed [VEC_W-1:0]  normal_y,
	input  wire logic signed [VEC_W-1:0]  normal_z,
	input  wire logic signed [VEC_W-1:0]  light_x,
	input  wire logic signed [VEC_W-1:0]  light_y,
	input  wire logic signed [VEC_W-1:0]  light_z,
	input  wire logic signed [VEC_W-1:0]  view_x,
	input  wire logic signed [VEC_W-1:0]  view_y,
	input  wire logic signed [VEC_W-1:0]  view_z,
	input  wire logic [RGB_W-1:0]         diffuse_rgb,
	input  wire logic                     front_face,

	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [CH_W-1:0]               color_red,
	output logic [CH_W-1:0]               color_green,
	output logic [CH_W-1:0]               color_blue
);

	// quotient bits of the cosine, enough for any unnormalised input
	localparam int QW    = 33 - VEC_FRAC_BITS;
	localparam int POS_W = $clog2(QW);
	localparam int DV_W  = SQ_W + VEC_FRAC_BITS;
	localparam int NUM_W = DOT_W + 24;
	// valid chain positions
	localparam int V_SQ0 = 3;
	localparam int V_DV0 = V_SQ0 + SQ_W;
	localparam int V_S4  = V_DV0 + QW;
	localparam int LAT   = V_S4 + 5;

	// configuration registers
	logic [CH_W-1:0]  spec_red_q;
	logic [CH_W-1:0]  spec_green_q;
	logic [CH_W-1:0]  spec_blue_q;
	logic [CFG_W-1:0] shininess_q;
	logic             diffuse_present_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spec_red_q        <= '0;
			spec_green_q      <= '0;
			spec_blue_q       <= '0;
			shininess_q       <= '0;
			diffuse_present_q <= 1'b1;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SPEC_RED:        spec_red_q        <= cfg_data;
				CFG_SPEC_GREEN:      spec_green_q      <= cfg_data;
				CFG_SPEC_BLUE:       spec_blue_q       <= cfg_data;
				CFG_SHININESS:       shininess_q       <= cfg_data;
				CFG_DIFFUSE_PRESENT: diffuse_present_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: the pipe moves unless a finished beat sits stalled
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv       = !(vld_q[LAT-1] && out_stall);
	assign in_stall  = !adv;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (adv)
			vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// s1: halfway sum (not normalised), normal and sideband
	logic signed [SUM_W-1:0] sx_s1, sy_s1, sz_s1;
	logic signed [VEC_W-1:0] nx_s1, ny_s1, nz_s1;
	side_t                   side_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s1   <= {light_x[VEC_W-1], light_x} + {view_x[VEC_W-1], view_x};
			sy_s1   <= {light_y[VEC_W-1], light_y} + {view_y[VEC_W-1], view_y};
			sz_s1   <= {light_z[VEC_W-1], light_z} + {view_z[VEC_W-1], view_z};
			nx_s1   <= normal_x;
			ny_s1   <= normal_y;
			nz_s1   <= normal_z;
			side_s1 <= '{diffuse_rgb: diffuse_rgb, front_face: front_face};
		end
	end

	// s2: per-axis products for the dot and the squared length
	logic signed [PROD_W-1:0] pdx_s2, pdy_s2, pdz_s2;
	logic signed [SQR_W-1:0]  psx_s2, psy_s2, psz_s2;
	side_t                    side_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pdx_s2  <= sx_s1 * nx_s1;
			pdy_s2  <= sy_s1 * ny_s1;
			pdz_s2  <= sz_s1 * nz_s1;
			psx_s2  <= sx_s1 * sx_s1;
			psy_s2  <= sy_s1 * sy_s1;
			psz_s2  <= sz_s1 * sz_s1;
			side_s2 <= side_s1;
		end
	end

	// s3: sums; a dot that is not positive feeds the divider zero
	logic signed [DOTS_W-1:0] dot_sum;
	logic [DOT_W-1:0]         dotp_s3;
	logic [LEN2_W-1:0]        len2_s3;
	side_t                    side_s3;

	assign dot_sum = DOTS_W'(pdx_s2) + DOTS_W'(pdy_s2) + DOTS_W'(pdz_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			dotp_s3 <= (dot_sum > 0) ? dot_sum[DOT_W-1:0] : '0;
			len2_s3 <= LEN2_W'(psx_s2[SQR_W-2:0]) + LEN2_W'(psy_s2[SQR_W-2:0])
				+ LEN2_W'(psz_s2[SQR_W-2:0]);
			side_s3 <= side_s2;
		end
	end

	// square root of len2 << 16, one result bit per stage
	logic [SQ_W:0]     sq_rem_d  [SQ_W];
	logic [SQ_W-1:0]   sq_root_d [SQ_W];
	logic [SQ_X_W-1:0] sq_x_d    [SQ_W];
	logic [SQ_W:0]     sq_rem_s  [SQ_W];
	logic [SQ_W-1:0]   sq_root_s [SQ_W];
	logic [SQ_X_W-1:0] sq_x_s    [SQ_W];
	logic [DOT_W-1:0]  sq_dot_s  [SQ_W];
	side_t             sq_side_s [SQ_W];

	for (genvar i = 0; i < SQ_W; i++) begin : g_sq
		logic [SQ_W:0]     rem_in;
		logic [SQ_W-1:0]   root_in;
		logic [SQ_X_W-1:0] x_in;
		logic [SQ_W+2:0]   rem2;
		logic [SQ_W+2:0]   trial;
		logic              ge;

		if (i == 0) begin : g_head
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = {len2_s3, 16'b0};
		end else begin : g_body
			assign rem_in  = sq_rem_s[i-1];
			assign root_in = sq_root_s[i-1];
			assign x_in    = sq_x_s[i-1];
		end

		assign rem2         = {rem_in, x_in[SQ_X_W-1 -: 2]};
		assign trial        = {1'b0, root_in, 2'b01};
		assign ge           = rem2 >= trial;
		assign sq_rem_d[i]  = ge ? (SQ_W+1)'(rem2 - trial) : (SQ_W+1)'(rem2);
		assign sq_root_d[i] = {root_in[SQ_W-2:0], ge};
		assign sq_x_d[i]    = {x_in[SQ_X_W-3:0], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_dot_s[0]  <= dotp_s3;
			sq_side_s[0] <= side_s3;
			for (int i = 1; i < SQ_W; i++) begin
				sq_dot_s[i]  <= sq_dot_s[i-1];
				sq_side_s[i] <= sq_side_s[i-1];
			end
			for (int i = 0; i < SQ_W; i++) begin
				sq_rem_s[i]  <= sq_rem_d[i];
				sq_root_s[i] <= sq_root_d[i];
				sq_x_s[i]    <= sq_x_d[i];
			end
		end
	end

	// cosine divider: (dot << 24) / (len8 << VEC_FRAC_BITS), one quotient bit per stage
	logic [NUM_W-1:0] dv_num;
	logic [DV_W-1:0]  dv_rem0;
	logic [DV_W-1:0]  dv_dvsr0;
	logic             dv_zero0;

	assign dv_num   = {sq_dot_s[SQ_W-1], 24'b0};
	assign dv_rem0  = DV_W'(dv_num >> QW);
	assign dv_dvsr0 = {sq_root_s[SQ_W-1], {VEC_FRAC_BITS{1'b0}}};
	assign dv_zero0 = (sq_root_s[SQ_W-1] == '0);

	logic [DV_W-1:0] dv_rem_d  [QW];
	logic [QW-1:0]   dv_q_d    [QW];
	logic [QW-1:0]   dv_nb_d   [QW];
	logic [DV_W-1:0] dv_rem_s  [QW];
	logic [QW-1:0]   dv_q_s    [QW];
	logic [QW-1:0]   dv_nb_s   [QW];
	logic [DV_W-1:0] dv_dvsr_s [QW];
	logic            dv_zero_s [QW];
	side_t           dv_side_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_dv
		logic [DV_W-1:0] rem_in;
		logic [DV_W-1:0] dvsr_in;
		logic [QW-1:0]   q_in;
		logic [QW-1:0]   nb_in;
		logic [DV_W:0]   rem2;
		logic            ge;

		if (i == 0) begin : g_head
			assign rem_in  = dv_rem0;
			assign dvsr_in = dv_dvsr0;
			assign q_in    = '0;
			assign nb_in   = dv_num[QW-1:0];
		end else begin : g_body
			assign rem_in  = dv_rem_s[i-1];
			assign dvsr_in = dv_dvsr_s[i-1];
			assign q_in    = dv_q_s[i-1];
			assign nb_in   = dv_nb_s[i-1];
		end

		assign rem2        = {rem_in, nb_in[QW-1]};
		assign ge          = rem2 >= {1'b0, dvsr_in};
		assign dv_rem_d[i] = ge ? DV_W'(rem2 - {1'b0, dvsr_in}) : DV_W'(rem2);
		assign dv_q_d[i]   = {q_in[QW-2:0], ge};
		assign dv_nb_d[i]  = {nb_in[QW-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_dvsr_s[0] <= dv_dvsr0;
			dv_zero_s[0] <= dv_zero0;
			dv_side_s[0] <= sq_side_s[SQ_W-1];
			for (int i = 1; i < QW; i++) begin
				dv_dvsr_s[i] <= dv_dvsr_s[i-1];
				dv_zero_s[i] <= dv_zero_s[i-1];
				dv_side_s[i] <= dv_side_s[i-1];
			end
			for (int i = 0; i < QW; i++) begin
				dv_rem_s[i] <= dv_rem_d[i];
				dv_q_s[i]   <= dv_q_d[i];
				dv_nb_s[i]  <= dv_nb_d[i];
			end
		end
	end

	// s4: leading one of the cosine and the log2 table lookup
	logic [QW-1:0]      cos_c;
	logic [POS_W-1:0]   msb_pos;
	logic [POS_W-1:0]   norm_sh;
	logic [QW+15:0]     norm_c;
	logic signed [5:0]  exp_int;
	logic signed [LG_W-1:0] lg_s4;
	logic               szero_s4;
	logic               czero_s4;
	side_t              side_s4;

	assign cos_c = dv_q_s[QW-1];

	always_comb begin
		msb_pos = '0;
		for (int b = 0; b < QW; b++) begin
			if (cos_c[b])
				msb_pos = POS_W'(b);
		end
	end

	assign norm_sh = POS_W'(QW - 1) - msb_pos;
	assign norm_c  = {cos_c, 16'b0} << norm_sh;
	assign exp_int = $signed(6'(msb_pos)) - 6'sd16;

	always_ff @(posedge clk) begin
		if (adv) begin
			lg_s4    <= {exp_int, LOG2_TAB[norm_c[QW+14 -: POW_IDX_W]]};
			szero_s4 <= dv_zero_s[QW-1];
			czero_s4 <= (cos_c == '0);
			side_s4  <= dv_side_s[QW-1];
		end
	end

	// s5: log2(c) * shininess, floored to q.16
	logic signed [E_W-1:0]   e_full;
	logic signed [E_W-9:0]   e_s5;
	logic                    szero_s5;
	logic                    czero_s5;
	side_t                   side_s5;

	assign e_full = lg_s4 * $signed({1'b0, shininess_q});

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s5     <= e_full[E_W-1:8];
			szero_s5 <= szero_s4;
			czero_s5 <= czero_s4;
			side_s5  <= side_s4;
		end
	end

	// s6: exp2 table and integer shift give the falloff
	logic signed [14:0] k_int;
	logic [14:0]        k_neg;
	logic [16:0]        mant;
	logic [FALL_W-1:0]  falloff;
	logic [FALL_W-1:0]  falloff_s6;
	side_t              side_s6;

	assign k_int = e_s5[30:16];
	assign k_neg = 15'(-k_int);
	assign mant  = EXP2_TAB[e_s5[15 -: POW_IDX_W]];

	always_comb begin
		if (szero_s5)
			falloff = '0;
		else if (czero_s5)
			falloff = (shininess_q == '0) ? FALLOFF_ONE : '0;
		else if (!k_int[14]) begin
			if (k_int >= 15'sd16)
				falloff = FALLOFF_CAP;
			else
				falloff = FALL_W'(mant) << k_int[3:0];
		end else if (k_neg > 15'd16)
			falloff = '0;
		else
			falloff = FALL_W'(mant >> k_neg[4:0]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			falloff_s6 <= falloff;
			side_s6    <= side_s5;
		end
	end

	// s7: specular scale and diffuse select, back faces take the override when diffuse is present
	logic [FALL_W+CH_W-1:0] mr, mg, mb;
	logic                   back_ovr;
	logic [FALL_W-1:0]      spec_r_s7, spec_g_s7, spec_b_s7;
	logic [CH_W-1:0]        dif_r_s7, dif_g_s7, dif_b_s7;

	assign mr       = falloff_s6 * spec_red_q;
	assign mg       = falloff_s6 * spec_green_q;
	assign mb       = falloff_s6 * spec_blue_q;
	assign back_ovr = diffuse_present_q && !side_s6.front_face;

	always_ff @(posedge clk) begin
		if (adv) begin
			spec_r_s7 <= back_ovr ? '0 : mr[FALL_W+CH_W-1:16];
			spec_g_s7 <= back_ovr ? '0 : mg[FALL_W+CH_W-1:16];
			spec_b_s7 <= back_ovr ? '0 : mb[FALL_W+CH_W-1:16];
			if (!diffuse_present_q) begin
				dif_r_s7 <= '0;
				dif_g_s7 <= '0;
				dif_b_s7 <= '0;
			end else if (back_ovr) begin
				dif_r_s7 <= BACK_RED;
				dif_g_s7 <= BACK_GREEN;
				dif_b_s7 <= BACK_BLUE;
			end else begin
				dif_r_s7 <= side_s6.diffuse_rgb[47:32];
				dif_g_s7 <= side_s6.diffuse_rgb[31:16];
				dif_b_s7 <= side_s6.diffuse_rgb[15:0];
			end
		end
	end

	// s8: add and saturate into the output register
	logic [FALL_W:0]   sum_r, sum_g, sum_b;
	logic [CH_W-1:0]   color_red_s8, color_green_s8, color_blue_s8;

	assign sum_r = (FALL_W+1)'(spec_r_s7) + (FALL_W+1)'(dif_r_s7);
	assign sum_g = (FALL_W+1)'(spec_g_s7) + (FALL_W+1)'(dif_g_s7);
	assign sum_b = (FALL_W+1)'(spec_b_s7) + (FALL_W+1)'(dif_b_s7);

	always_ff @(posedge clk) begin
		if (adv) begin
			color_red_s8   <= (sum_r[FALL_W:CH_W] != '0) ? '1 : sum_r[CH_W-1:0];
			color_green_s8 <= (sum_g[FALL_W:CH_W] != '0) ? '1 : sum_g[CH_W-1:0];
			color_blue_s8  <= (sum_b[FALL_W:CH_W] != '0) ? '1 : sum_b[CH_W-1:0];
		end
	end

	assign color_red   = color_red_s8;
	assign color_green = color_green_s8;
	assign color_blue  = color_blue_s8;

	// first divider remainder below the divisor keeps the cosine inside QW bits
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V_DV0-1] && !dv_zero0 |-> dv_rem0 < dv_dvsr0)
		else $error("cosine quotient exceeds divider width");

	// falloff never passes the cap
	a_fall_cap: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V_S4+2] |-> falloff_s6 <= FALLOFF_CAP)
		else $error("falloff above cap");

	// a back-face hit with diffuse present carries only the override color
	a_back_face: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V_S4+1] && adv && back_ovr |=>
			spec_r_s7 == '0 && spec_g_s7 == '0 && spec_b_s7 == '0
			&& dif_r_s7 == BACK_RED && dif_g_s7 == BACK_GREEN && dif_b_s7 == BACK_BLUE)
		else $error("back-face override not applied");

endmodule

`default_nettype wire

// ----- sim/blinn_phong_shader_core_tb.sv -----
// self-checking testbench for the blinn-phong shader core
`timescale 1ns / 1ps

module blinn_phong_shader_core_tb
	import bps_pkg::*;
;

	localparam int FRAC      = 14;
	localparam int DEPTH     = 256;
	localparam int LATENCY   = 3 + 25 + (33 - FRAC) + 5;
	localparam int DOG_LIMIT = 20000;
	localparam int N_RANDOM  = 1600;

	typedef struct {
		logic signed [15:0] n [3];
		logic signed [15:0] l [3];
		logic signed [15:0] v [3];
		logic [47:0]        rgb;
		logic               front;
	} hit_t;

	typedef struct {
		logic [15:0] r;
		logic [15:0] g;
		logic [15:0] b;
	} color_t;

	// error counter shared by the scoreboard and the end-of-run check
	int errors = 0;

	task automatic report(input string what);
		errors++;
		if (errors <= 40)
			$display("mismatch at %0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------------
	// shading predictor: own copy of the log2/exp2 tables and registers
	// ---------------------------------------------------------------------
	class shade_scoreboard;
		logic [15:0] lg_tab [DEPTH];
		logic [16:0] ex_tab [DEPTH];
		logic [15:0] spec [3];
		logic [15:0] shine;
		bit          diffuse_on;
		color_t      pending [$];
		int          checked;

		function new();
			longint unsigned y, t, lo, hi, mid;
			for (int i = 0; i < DEPTH; i++) begin
				y = (64'd1 << 30) + ((longint'(i) << 30) / DEPTH);
				lg_tab[i] = 16'(log_frac(y));
				t = (longint'(i) << 16) / DEPTH;
				lo = 65536;
				hi = 131071;
				while (lo < hi) begin
					mid = (lo + hi) >> 1;
					if (log_frac(mid << 14) >= t)
						hi = mid;
					else
						lo = mid + 1;
				end
				ex_tab[i] = lo[16:0];
			end
			spec = '{16'd0, 16'd0, 16'd0};
			shine = 0;
			diffuse_on = 1;
			checked = 0;
		endfunction

		// truncated q.16 fraction of log2 by repeated squaring in q2.30
		function longint unsigned log_frac(input longint unsigned y_in);
			longint unsigned y, r;
			y = y_in;
			r = 0;
			for (int b = 0; b < 16; b++) begin
				y = (y * y) >> 30;
				r = r << 1;
				if (y >= (64'd1 << 31)) begin
					y = y >> 1;
					r = r | 1;
				end
			end
			return r;
		endfunction

		function longint unsigned int_sqrt(input longint unsigned val);
			longint unsigned r, bitv, x;
			x = val;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > x)
				bitv = bitv >> 2;
			while (bitv != 0) begin
				if (x >= r + bitv) begin
					x = x - (r + bitv);
					r = (r >> 1) + bitv;
				end else begin
					r = r >> 1;
				end
				bitv = bitv >> 2;
			end
			return r;
		endfunction

		function longint div_floor(input longint a, input longint d);
			if (a >= 0)
				return a / d;
			return -((-a + d - 1) / d);
		endfunction

		// falloff in q.16 for a positive q.16 cosine
		function longint unsigned falloff_of(input longint unsigned c);
			int p;
			longint unsigned f16, mant, f;
			longint lg, e, k, fr;
			p = 63;
			while (p > 0 && c[p] == 1'b0)
				p--;
			if (p >= 16)
				f16 = (c >> (p - 16)) & 64'hFFFF;
			else
				f16 = (c << (16 - p)) & 64'hFFFF;
			lg = longint'(p - 16) * 65536 + longint'(lg_tab[(f16 * DEPTH) >> 16]);
			e = div_floor(lg * longint'(shine), 256);
			k = div_floor(e, 65536);
			fr = e - k * 65536;
			mant = ex_tab[(longint'(fr) * DEPTH) >> 16];
			if (k >= 16)
				return 64'd1 << 32;
			if (k >= 0) begin
				f = mant << k;
				return (f > (64'd1 << 32)) ? (64'd1 << 32) : f;
			end
			if (-k >= 63)
				return 0;
			return mant >> (-k);
		endfunction

		function void write_reg(input cfg_reg_t idx, input logic [15:0] val);
			case (idx)
				CFG_SPEC_RED:        spec[0] = val;
				CFG_SPEC_GREEN:      spec[1] = val;
				CFG_SPEC_BLUE:       spec[2] = val;
				CFG_SHININESS:       shine = val;
				CFG_DIFFUSE_PRESENT: diffuse_on = val[0];
				default: ;
			endcase
		endfunction

		// note an accepted hit and queue its shaded color
		function void note_hit(input hit_t h);
			longint s [3];
			longint dotp, len2;
			longint unsigned len8, fall, c, sum;
			longint unsigned sp [3], df [3], ch [3];
			color_t col;
			for (int a = 0; a < 3; a++)
				s[a] = longint'(h.l[a]) + longint'(h.v[a]);
			dotp = s[0] * h.n[0] + s[1] * h.n[1] + s[2] * h.n[2];
			len2 = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
			len8 = int_sqrt(longint'(len2) << 16);
			if (len8 == 0) begin
				fall = 0;
			end else begin
				c = 0;
				if (dotp > 0)
					c = (longint'(dotp) << 24) / (len8 << FRAC);
				if (c == 0)
					fall = (shine == 0) ? 65536 : 0;
				else
					fall = falloff_of(c);
			end
			for (int a = 0; a < 3; a++) begin
				sp[a] = (fall * spec[a]) >> 16;
				df[a] = 0;
			end
			if (diffuse_on) begin
				df[0] = h.rgb[47:32];
				df[1] = h.rgb[31:16];
				df[2] = h.rgb[15:0];
				if (!h.front) begin
					df = '{BACK_RED, BACK_GREEN, BACK_BLUE};
					sp = '{0, 0, 0};
				end
			end
			for (int a = 0; a < 3; a++) begin
				sum = sp[a] + df[a];
				ch[a] = (sum > 65535) ? 65535 : sum;
			end
			col.r = ch[0][15:0];
			col.g = ch[1][15:0];
			col.b = ch[2][15:0];
			pending.push_back(col);
		endfunction

		// compare one result beat with the oldest expected color
		task check_color(input color_t got);
			color_t want;
			if (pending.size() == 0) begin
				report("result beat with no hit pending");
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.r !== want.r)
				report($sformatf("red %0d, expected %0d", got.r, want.r));
			if (got.g !== want.g)
				report($sformatf("green %0d, expected %0d", got.g, want.g));
			if (got.b !== want.b)
				report($sformatf("blue %0d, expected %0d", got.b, want.b));
		endtask
	endclass

	// ---------------------------------------------------------------------
	// block under test
	// ---------------------------------------------------------------------
	logic clk = 0;
	logic arst_n = 0;
	logic cfg_write = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [VEC_W-1:0] normal_x = 0, normal_y = 0, normal_z = 0;
	logic signed [VEC_W-1:0] light_x = 0, light_y = 0, light_z = 0;
	logic signed [VEC_W-1:0] view_x = 0, view_y = 0, view_z = 0;
	logic [RGB_W-1:0] diffuse_rgb = '0;
	logic front_face = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [CH_W-1:0] color_red, color_green, color_blue;

	blinn_phong_shader_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.light_x(light_x), .light_y(light_y), .light_z(light_z),
		.view_x(view_x), .view_y(view_y), .view_z(view_z),
		.diffuse_rgb(diffuse_rgb), .front_face(front_face),
		.out_valid(out_valid), .out_stall(out_stall),
		.color_red(color_red), .color_green(color_green), .color_blue(color_blue)
	);

	shade_scoreboard sb = new();

	initial begin
		forever #5 clk = ~clk;
	end

	// idling is switched off for a long stretch in the middle of the random part
	bit calm = 0;
	int hits_sent = 0;
	int idle_cycles = 0;

	// ---------------------------------------------------------------------
	// result side: random stall, check every accepted result beat
	// ---------------------------------------------------------------------
	always @(posedge clk) begin
		color_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.r = color_red;
				got.g = color_green;
				got.b = color_blue;
				sb.check_color(got);
			end
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 32);
		end
	end

	// watchdog: cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= DOG_LIMIT) begin
				$display("watchdog expired with %0d results pending", sb.pending.size());
				$display("blinn_phong_shader_core_tb NOT OK");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// driver tasks
	// ---------------------------------------------------------------------
	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_regs(input logic [15:0] r, input logic [15:0] g,
				input logic [15:0] b, input logic [15:0] sh, input bit dp);
		write_reg(CFG_SPEC_RED, r);
		write_reg(CFG_SPEC_GREEN, g);
		write_reg(CFG_SPEC_BLUE, b);
		write_reg(CFG_SHININESS, sh);
		write_reg(CFG_DIFFUSE_PRESENT, {15'd0, dp});
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// drive one hit, holding it until it is accepted, optional idle first
	task automatic send_hit(input hit_t h);
		if (!calm) begin
			while ($urandom_range(99) < 32) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		{normal_x, normal_y, normal_z} <= {h.n[0], h.n[1], h.n[2]};
		{light_x, light_y, light_z} <= {h.l[0], h.l[1], h.l[2]};
		{view_x, view_y, view_z} <= {h.v[0], h.v[1], h.v[2]};
		diffuse_rgb <= h.rgb;
		front_face <= h.front;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_hit(h);
		hits_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
	endtask

	// wait for every pending result, then let the pipe drain
	task automatic drain();
		end_burst();
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] comp_rand(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(33000)) - 16500);
			default: return $signed(16'($urandom_range(16384)));
		endcase
	endfunction

	// mostly plausible unit-ish hits, some raw noise and degenerate halfways
	function automatic hit_t rand_hit();
		hit_t h;
		int mode, pick;
		pick = $urandom_range(99);
		mode = (pick < 20) ? 0 : 1;
		for (int a = 0; a < 3; a++) begin
			h.n[a] = comp_rand(mode);
			h.l[a] = comp_rand(mode);
			h.v[a] = comp_rand(mode);
		end
		if (pick >= 90) begin
			for (int a = 0; a < 3; a++)
				h.v[a] = -h.l[a];
		end else if (pick >= 75) begin
			// normal aligned with the halfway so the cosine sits near one
			for (int a = 0; a < 3; a++)
				h.n[a] = (h.l[a] >>> 1) + (h.v[a] >>> 1);
		end
		h.rgb = 48'({$urandom, $urandom});
		if ($urandom_range(3) == 0)
			h.rgb = h.rgb & 48'h1FFF_1FFF_1FFF;
		h.front = ($urandom_range(3) != 0);
		return h;
	endfunction

	function automatic hit_t make_hit(input logic signed [15:0] n, input logic signed [15:0] l,
					 input logic signed [15:0] v, input logic [47:0] rgb, input bit f);
		hit_t h;
		h.n = '{n, n, n};
		h.l = '{l, l, l};
		h.v = '{v, v, v};
		h.rgb = rgb;
		h.front = f;
		return h;
	endfunction

	// ---------------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------------
	initial begin
		hit_t h;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset registers, then strong specular with shininess one
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'h1000_2000_3000, 1));
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'hFFFF_FFFF_FFFF, 0));
		drain();
		set_regs(16'hFFFF, 16'h8000, 16'h1000, 16'h0100, 1'b1);
		// cosine near one, overflowing channel
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'hFFFF_0000_8000, 1));
		// back face override
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'h1234_5678_9ABC, 0));
		// cosine negative
		send_hit(make_hit(-16'sd16384, 16'sd16384, 16'sd16384, 48'h0, 1));
		// zero-length halfway
		send_hit(make_hit(16'sd16384, 16'sd16384, -16'sd16384, 48'h0001_0001_0001, 1));
		// cosine above one, extremes of components
		send_hit(make_hit(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 48'h0, 1));
		send_hit(make_hit(16'sh8000, 16'sh8000, 16'sh8000, 48'h0, 1));
		send_hit(make_hit(16'sh7FFF, 16'sh8000, 16'sh8000, 48'h0, 1));
		send_hit(make_hit(16'sd1, 16'sd1, 16'sd0, 48'h0, 1));
		drain();
		// shininess zero: negative cosine gives full specular
		set_regs(16'h1000, 16'h2000, 16'h3000, 16'h0000, 1'b0);
		send_hit(make_hit(-16'sd16384, 16'sd16384, 16'sd16384, 48'hFFFF_FFFF_FFFF, 0));
		send_hit(make_hit(16'sd16384, 16'sd16384, -16'sd16384, 48'hFFFF_FFFF_FFFF, 1));
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'h0, 1));
		drain();
		// highest shininess, huge cosine
		set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_hit(make_hit(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 48'h0, 1));
		send_hit(make_hit(16'sd9459, 16'sd9459, 16'sd9459, 48'h0, 1));
		send_hit(make_hit(16'sd9000, 16'sd9459, 16'sd9459, 48'h0, 1));
		send_hit(make_hit(16'sd100, 16'sd9459, 16'sd9459, 48'h0, 1));
		drain();

		// random part in several register phases
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_regs(16'h1000, 16'h1000, 16'h1000, 16'h0800, 1'b1);
				1: set_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
				7: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
				default: set_regs(16'($urandom), 16'($urandom), 16'($urandom),
						($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192))),
						1'($urandom));
			endcase
			calm = (phase == 4);
			for (int i = 0; i < N_RANDOM / 8; i++) begin
				h = rand_hit();
				send_hit(h);
			end
			drain();
			calm = 0;
		end

		$display("sent %0d hits, checked %0d colors over 12 register settings",
			hits_sent, sb.checked);
		if (errors == 0 && sb.pending.size() == 0)
			$display("blinn_phong_shader_core_tb OK");
		else
			$display("blinn_phong_shader_core_tb NOT OK");
		$finish;
	end

endmodule
